>>> rtl/rv2m_pkg.sv
// Shared types, constants and helper functions for the rotation vector to matrix block.
package rv2m_pkg;

  localparam int ITERATIONS = 16;
  localparam int IN_FRAC_BITS_DEF = 12;
  localparam int OUT_FRAC_BITS = 14;
  localparam int QDEPTH = 2;

  localparam logic signed [35:0] ONE_Q30 = 36'sd1073741824;
  localparam logic signed [35:0] TWO_PI_Q30 = 36'sd6746518852;
  localparam logic signed [35:0] PI_Q30 = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [35:0] GAIN_Q30 = 36'sd652032874;

  // multiplier schedule
  localparam logic [3:0] M_XX = 4'd0;
  localparam logic [3:0] M_YY = 4'd1;
  localparam logic [3:0] M_ZZ = 4'd2;
  localparam logic [3:0] M_XY = 4'd3;
  localparam logic [3:0] M_XZ = 4'd4;
  localparam logic [3:0] M_YZ = 4'd5;
  localparam logic [3:0] M_CXY = 4'd6;
  localparam logic [3:0] M_CXZ = 4'd7;
  localparam logic [3:0] M_CYZ = 4'd8;
  localparam logic [3:0] M_SX = 4'd9;
  localparam logic [3:0] M_SY = 4'd10;
  localparam logic [3:0] M_SZ = 4'd11;
  localparam logic [3:0] M_CYYZZ = 4'd12;
  localparam logic [3:0] M_CXXZZ = 4'd13;
  localparam logic [3:0] M_CXXYY = 4'd14;
  localparam int NUM_MUL = 15;

  typedef struct packed {
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
  } in_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } out_t;

  typedef struct packed {
    in_t         vec;
    logic [31:0] n2;
    logic        zero;
  } job_t;

  function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
    logic signed [35:0] a;
    unique case (i)
      5'd0:  a = 36'sd843314857;
      5'd1:  a = 36'sd497837829;
      5'd2:  a = 36'sd263043837;
      5'd3:  a = 36'sd133525159;
      5'd4:  a = 36'sd67021687;
      5'd5:  a = 36'sd33543516;
      5'd6:  a = 36'sd16775851;
      5'd7:  a = 36'sd8388437;
      5'd8:  a = 36'sd4194283;
      5'd9:  a = 36'sd2097149;
      5'd10: a = 36'sd1048576;
      5'd11: a = 36'sd524288;
      5'd12: a = 36'sd262144;
      5'd13: a = 36'sd131072;
      5'd14: a = 36'sd65536;
      5'd15: a = 36'sd32768;
      5'd16: a = 36'sd16384;
      5'd17: a = 36'sd8192;
      5'd18: a = 36'sd4096;
      5'd19: a = 36'sd2048;
      5'd20: a = 36'sd1024;
      5'd21: a = 36'sd512;
      5'd22: a = 36'sd256;
      5'd23: a = 36'sd128;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Q30 to output format: round half up, clamp to +-1, then to 16 bits
  function automatic logic signed [15:0] to_out(input logic signed [37:0] v);
    logic signed [38:0] r;
    logic signed [38:0] lim;
    r = (39'(v) + (39'sd1 <<< (30 - OUT_FRAC_BITS - 1))) >>> (30 - OUT_FRAC_BITS);
    lim = 39'sd1 <<< OUT_FRAC_BITS;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    if (r > 39'sd32767) r = 39'sd32767;
    if (r < -39'sd32768) r = -39'sd32768;
    return r[15:0];
  endfunction

endpackage

>>> rtl/rv2m_queue.sv
// Small register FIFO used between front and back and on the result side.
module rv2m_queue #(
  parameter int W = 1,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] count;
  logic          wr;
  logic          rd;

  assign full  = count == CW'(DEPTH);
  assign empty = count == '0;
  assign wr    = push && !full;
  assign rd    = pop && !empty;
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (wr) wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      if (rd) rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      if (wr && !rd) count <= count + 1'b1;
      else if (rd && !wr) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= din;
  end

endmodule

>>> rtl/rv2m_front.sv
// Front end: takes vectors, forms the squared norm, flags the zero vector, queues the job.
module rv2m_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rv2m_pkg::in_t item,
  output logic          full,
  input  logic          job_pop,
  output rv2m_pkg::job_t job,
  output logic          job_empty
);

  logic signed [31:0] sx;
  logic signed [31:0] sy;
  logic signed [31:0] sz;
  rv2m_pkg::job_t     wj;

  always_comb begin
    sx = item.rot_x * item.rot_x;
    sy = item.rot_y * item.rot_y;
    sz = item.rot_z * item.rot_z;
    wj.vec  = item;
    wj.n2   = sx + sy + sz;
    wj.zero = wj.n2 == 32'd0;
  end

  rv2m_queue #(
    .W     ($bits(rv2m_pkg::job_t)),
    .DEPTH (rv2m_pkg::QDEPTH)
  ) u_jobq (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (wj),
    .full  (full),
    .pop   (job_pop),
    .dout  (job),
    .empty (job_empty)
  );

endmodule

>>> rtl/rv2m_back.sv
// Back end: iterative norm, angle reduction, CORDIC, axis division and matrix products.
module rv2m_back #(
  parameter int IN_FRAC_BITS = rv2m_pkg::IN_FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  rv2m_pkg::job_t  job,
  input  logic            job_empty,
  output logic            job_pop,
  output rv2m_pkg::out_t  res,
  input  logic            res_full,
  output logic            res_push
);

  localparam int SH_L  = (IN_FRAC_BITS <= 16) ? 16 - IN_FRAC_BITS : 0;
  localparam int SH_R  = (IN_FRAC_BITS > 16) ? IN_FRAC_BITS - 16 : 0;
  localparam int ANG_W = 31 + SH_L - SH_R;
  localparam int RW    = ((ANG_W > 34) ? ANG_W : 34) + 1;
  localparam int RED_STEPS = (ANG_W > 32) ? ANG_W - 32 : 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SQRT = 6'b000010,
    S_RED  = 6'b000100,
    S_FOLD = 6'b001000,
    S_ROT  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state;
  logic   in_mul;
  logic [4:0] cnt;
  logic   zero;
  logic signed [15:0] vv [3];

  logic [33:0] sq_src;
  logic [34:0] sq_rem;
  logic [30:0] sq_root;
  logic [RW-1:0] red;
  logic signed [35:0] cx, cy, cz;
  logic   flip;
  logic [31:0] dq_rem [3];
  logic [30:0] dq_q [3];
  logic signed [31:0] u [3];
  logic signed [33:0] s_r, cc_r;
  logic signed [33:0] sum_yz, sum_xz, sum_xy;
  logic signed [35:0] prd [rv2m_pkg::NUM_MUL];

  logic [34:0] sq_cur, sq_trial, sq_rem_next;
  logic [30:0] sq_root_next;
  logic        sq_ge;
  logic [RW-1:0] ang, red_sub, red_next;
  logic signed [35:0] fr0, fr1, fz;
  logic        fl;
  logic signed [35:0] dx, dy, at;
  logic [32:0] dv_cur [3];
  logic [32:0] dv_t;
  logic [15:0] mag [3];
  logic [30:0] qc [3];
  logic signed [33:0] ma, mb;
  logic signed [67:0] mp;
  logic signed [37:0] e [9];

  always_comb begin
    sq_cur = {sq_rem[32:0], sq_src[33:32]};
    sq_trial = {2'b00, sq_root, 2'b01};
    sq_ge = sq_cur >= sq_trial;
    sq_root_next = {sq_root[29:0], sq_ge};
    sq_rem_next = sq_ge ? sq_cur - sq_trial : sq_cur;
    ang = (RW'(sq_root_next) << SH_L) >> SH_R;

    red_sub = RW'(rv2m_pkg::TWO_PI_Q30[32:0]) << cnt[2:0];
    red_next = (red >= red_sub) ? red - red_sub : red;

    fr0 = 36'(red);
    fr1 = (fr0 > rv2m_pkg::PI_Q30) ? fr0 - rv2m_pkg::TWO_PI_Q30 : fr0;
    if (fr1 > rv2m_pkg::HALF_PI_Q30) begin
      fz = fr1 - rv2m_pkg::PI_Q30;
      fl = 1'b1;
    end else if (fr1 < -rv2m_pkg::HALF_PI_Q30) begin
      fz = fr1 + rv2m_pkg::PI_Q30;
      fl = 1'b1;
    end else begin
      fz = fr1;
      fl = 1'b0;
    end

    dx = cy >>> cnt;
    dy = cx >>> cnt;
    at = rv2m_pkg::atan_q30(cnt);

    dv_t = {2'b00, sq_root};
    for (int k = 0; k < 3; k++) begin
      dv_cur[k] = {dq_rem[k], 1'b0};
      mag[k] = vv[k][15] ? 16'(-vv[k]) : 16'(vv[k]);
      qc[k] = (dq_q[k] > 31'd1073741824) ? 31'd1073741824 : dq_q[k];
    end
  end

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cnt[3:0])
      rv2m_pkg::M_XX:    begin ma = 34'(u[0]); mb = 34'(u[0]); end
      rv2m_pkg::M_YY:    begin ma = 34'(u[1]); mb = 34'(u[1]); end
      rv2m_pkg::M_ZZ:    begin ma = 34'(u[2]); mb = 34'(u[2]); end
      rv2m_pkg::M_XY:    begin ma = 34'(u[0]); mb = 34'(u[1]); end
      rv2m_pkg::M_XZ:    begin ma = 34'(u[0]); mb = 34'(u[2]); end
      rv2m_pkg::M_YZ:    begin ma = 34'(u[1]); mb = 34'(u[2]); end
      rv2m_pkg::M_CXY:   begin ma = cc_r; mb = 34'(prd[rv2m_pkg::M_XY]); end
      rv2m_pkg::M_CXZ:   begin ma = cc_r; mb = 34'(prd[rv2m_pkg::M_XZ]); end
      rv2m_pkg::M_CYZ:   begin ma = cc_r; mb = 34'(prd[rv2m_pkg::M_YZ]); end
      rv2m_pkg::M_SX:    begin ma = s_r; mb = 34'(u[0]); end
      rv2m_pkg::M_SY:    begin ma = s_r; mb = 34'(u[1]); end
      rv2m_pkg::M_SZ:    begin ma = s_r; mb = 34'(u[2]); end
      rv2m_pkg::M_CYYZZ: begin ma = cc_r; mb = sum_yz; end
      rv2m_pkg::M_CXXZZ: begin ma = cc_r; mb = sum_xz; end
      rv2m_pkg::M_CXXYY: begin ma = cc_r; mb = sum_xy; end
      default:           begin ma = '0; mb = '0; end
    endcase
    mp = ma * mb;
  end

  always_comb begin
    e[0] = 38'(rv2m_pkg::ONE_Q30) - 38'(prd[rv2m_pkg::M_CYYZZ]);
    e[1] = 38'(prd[rv2m_pkg::M_CXY]) - 38'(prd[rv2m_pkg::M_SZ]);
    e[2] = 38'(prd[rv2m_pkg::M_SY]) + 38'(prd[rv2m_pkg::M_CXZ]);
    e[3] = 38'(prd[rv2m_pkg::M_SZ]) + 38'(prd[rv2m_pkg::M_CXY]);
    e[4] = 38'(rv2m_pkg::ONE_Q30) - 38'(prd[rv2m_pkg::M_CXXZZ]);
    e[5] = 38'(prd[rv2m_pkg::M_CYZ]) - 38'(prd[rv2m_pkg::M_SX]);
    e[6] = 38'(prd[rv2m_pkg::M_CXZ]) - 38'(prd[rv2m_pkg::M_SY]);
    e[7] = 38'(prd[rv2m_pkg::M_SX]) + 38'(prd[rv2m_pkg::M_CYZ]);
    e[8] = 38'(rv2m_pkg::ONE_Q30) - 38'(prd[rv2m_pkg::M_CXXYY]);
    if (zero) begin
      for (int k = 0; k < 9; k++) begin
        e[k] = (k % 4 == 0) ? 38'(rv2m_pkg::ONE_Q30) : '0;
      end
    end
    res.m00 = rv2m_pkg::to_out(e[0]);
    res.m01 = rv2m_pkg::to_out(e[1]);
    res.m02 = rv2m_pkg::to_out(e[2]);
    res.m10 = rv2m_pkg::to_out(e[3]);
    res.m11 = rv2m_pkg::to_out(e[4]);
    res.m12 = rv2m_pkg::to_out(e[5]);
    res.m20 = rv2m_pkg::to_out(e[6]);
    res.m21 = rv2m_pkg::to_out(e[7]);
    res.m22 = rv2m_pkg::to_out(e[8]);
  end

  assign job_pop  = (state == S_IDLE) && !in_mul && !job_empty;
  assign res_push = (state == S_DONE) && !res_full;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      in_mul <= 1'b0;
      cnt    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_mul) begin
            cnt <= cnt + 1'b1;
            if (cnt[3:0] == rv2m_pkg::M_CXXYY) begin
              in_mul <= 1'b0;
              state  <= S_DONE;
            end
          end else if (!job_empty) begin
            cnt   <= '0;
            state <= job.zero ? S_DONE : S_SQRT;
          end
        end
        S_SQRT: begin
          cnt <= cnt + 1'b1;
          if (cnt == 5'd30) begin
            cnt   <= 5'(RED_STEPS - 1);
            state <= S_RED;
          end
        end
        S_RED: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) state <= S_FOLD;
        end
        S_FOLD: begin
          cnt   <= '0;
          state <= S_ROT;
        end
        S_ROT: begin
          cnt <= cnt + 1'b1;
          if (cnt == 5'd31) begin
            in_mul <= 1'b1;
            state  <= S_IDLE;
          end
        end
        S_DONE: begin
          if (!res_full) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (job_pop) begin
      vv[0]   <= job.vec.rot_x;
      vv[1]   <= job.vec.rot_y;
      vv[2]   <= job.vec.rot_z;
      zero    <= job.zero;
      sq_src  <= {2'b00, job.n2};
      sq_rem  <= '0;
      sq_root <= '0;
    end
    if (state == S_SQRT) begin
      sq_src  <= {sq_src[31:0], 2'b00};
      sq_rem  <= sq_rem_next;
      sq_root <= sq_root_next;
      if (cnt == 5'd30) begin
        red <= ang;
        for (int k = 0; k < 3; k++) begin
          dq_rem[k] <= {3'b000, mag[k], 13'd0};
          dq_q[k]   <= '0;
        end
      end
    end
    if (state == S_RED) red <= red_next;
    if (state == S_FOLD) begin
      cx   <= rv2m_pkg::GAIN_Q30;
      cy   <= '0;
      cz   <= fz;
      flip <= fl;
    end
    if (state == S_ROT) begin
      if (cnt < 5'(rv2m_pkg::ITERATIONS)) begin
        if (!cz[35]) begin
          cx <= cx - dx;
          cy <= cy + dy;
          cz <= cz - at;
        end else begin
          cx <= cx + dx;
          cy <= cy - dy;
          cz <= cz + at;
        end
      end
      if (cnt != 5'd31) begin
        for (int k = 0; k < 3; k++) begin
          if (dv_cur[k] >= dv_t) begin
            dq_rem[k] <= 32'(dv_cur[k] - dv_t);
            dq_q[k]   <= {dq_q[k][29:0], 1'b1};
          end else begin
            dq_rem[k] <= dv_cur[k][31:0];
            dq_q[k]   <= {dq_q[k][29:0], 1'b0};
          end
        end
      end else begin
        s_r  <= flip ? 34'(-cy) : 34'(cy);
        cc_r <= 34'(rv2m_pkg::ONE_Q30) - (flip ? 34'(-cx) : 34'(cx));
        for (int k = 0; k < 3; k++) begin
          u[k] <= vv[k][15] ? -$signed({1'b0, qc[k]}) : $signed({1'b0, qc[k]});
        end
      end
    end
    if (in_mul) begin
      prd[cnt[3:0]] <= mp[65:30];
      if (cnt[3:0] == rv2m_pkg::M_CXY) begin
        sum_yz <= 34'(prd[rv2m_pkg::M_YY]) + 34'(prd[rv2m_pkg::M_ZZ]);
        sum_xz <= 34'(prd[rv2m_pkg::M_XX]) + 34'(prd[rv2m_pkg::M_ZZ]);
        sum_xy <= 34'(prd[rv2m_pkg::M_XX]) + 34'(prd[rv2m_pkg::M_YY]);
      end
    end
  end

endmodule

>>> rtl/rotation_vector_to_matrix.sv
// Rotation vector (Q4.12 radians) to 3x3 rotation matrix (Q2.14) by the Rodrigues formula.
// A vector is taken whenever full is low; up to two wait in the job queue while the engine
// works. The engine is one iterative unit: a 31-step bit-serial square root for the norm,
// a modulo-2pi reduction of one step per cycle, a CORDIC rotation alongside three
// bit-serial axis dividers, and 15 products through one shared multiplier. The engine takes
// a new vector only once it has pushed the last result, and so sets the sustained rate.
// Results wait in a two-beat queue, so the engine carries on while the consumer holds off
// pop.
module rotation_vector_to_matrix #(
  parameter int IN_FRAC_BITS = rv2m_pkg::IN_FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rv2m_pkg::in_t  item,
  output logic           full,
  input  logic           pop,
  output rv2m_pkg::out_t result,
  output logic           empty
);

  localparam int CAPACITY = 2 * rv2m_pkg::QDEPTH + 1;

  rv2m_pkg::job_t job;
  logic           job_empty;
  logic           job_pop;
  rv2m_pkg::out_t res;
  logic           res_full;
  logic           res_push;
  logic [3:0]     inflight;

  rv2m_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .job_pop   (job_pop),
    .job       (job),
    .job_empty (job_empty)
  );

  rv2m_back #(
    .IN_FRAC_BITS (IN_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (job),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .res       (res),
    .res_full  (res_full),
    .res_push  (res_push)
  );

  rv2m_queue #(
    .W     ($bits(rv2m_pkg::out_t)),
    .DEPTH (rv2m_pkg::QDEPTH)
  ) u_resq (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res),
    .full  (res_full),
    .pop   (pop),
    .dout  (result),
    .empty (empty)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + 4'(push && !full) - 4'(pop && !empty);
    end
  end

  a_inflight_bound: assert property (@(posedge clk) disable iff (rst)
    inflight <= 4'(CAPACITY))
    else $error("more beats in flight than the block can hold");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $fell(empty) |-> $past(res_push))
    else $error("result appeared without an engine push");

  a_diag_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.m00 <= 16'sd16384 && result.m00 >= -16'sd16384 &&
                result.m11 <= 16'sd16384 && result.m11 >= -16'sd16384 &&
                result.m22 <= 16'sd16384 && result.m22 >= -16'sd16384))
    else $error("diagonal entry beyond unit range");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("engine pushed into a full result queue");

endmodule
